// ----- design/spg_pkg.sv -----
// Package: shared types, codes and widths for the step-pulse generator.
package spg_pkg;

    localparam int CLK_W = 26;
    localparam int VEL_W = 24;
    localparam int POS_W = 32;
    localparam int ACT_W = 3;
    localparam int CFG_W = 24;

    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_MOVE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ENABLE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DISABLE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_HOME    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_ACK     = 3'd5;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_MOVE,
        OP_ENABLE,
        OP_DISABLE,
        OP_HOME,
        OP_ACK,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        REG_CLOCK_RATE,
        REG_MAX_VELOCITY,
        REG_PULSE_WIDTH,
        REG_COUNTER_MAX,
        REG_MIN_POSITION,
        REG_MAX_POSITION,
        REG_HOME_POSITION,
        REG_INVERT_PULSE
    } reg_idx_t;

    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } bk_state_t;

    // Classified request as held in the queue; spd is already clamped.
    typedef struct packed {
        op_t              op;
        logic [VEL_W-1:0] spd;
        logic             dir;
    } req_t;

endpackage

// ----- design/spg_front.sv -----
// Front end: accepts requests, classifies the action, clamps speed, two-entry queue.
module spg_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [spg_pkg::ACT_W-1:0]   action,
    input  logic [spg_pkg::VEL_W-1:0]   speed,
    input  logic                        move_dir,
    input  logic [spg_pkg::VEL_W-1:0]   max_velocity,
    input  logic                        pop,
    output spg_pkg::req_t               head,
    output logic                        head_valid
);

    spg_pkg::req_t q_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          push;
    spg_pkg::req_t req;

    always_comb
    begin
        case (action)
            spg_pkg::ACT_TICK:    req.op = spg_pkg::OP_TICK;
            spg_pkg::ACT_MOVE:    req.op = spg_pkg::OP_MOVE;
            spg_pkg::ACT_ENABLE:  req.op = spg_pkg::OP_ENABLE;
            spg_pkg::ACT_DISABLE: req.op = spg_pkg::OP_DISABLE;
            spg_pkg::ACT_HOME:    req.op = spg_pkg::OP_HOME;
            spg_pkg::ACT_ACK:     req.op = spg_pkg::OP_ACK;
            default:              req.op = spg_pkg::OP_NONE;
        endcase
        req.spd = (speed > max_velocity) ? max_velocity : speed;
        req.dir = move_dir;
    end

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= req;
        end
    end

endmodule

// ----- design/spg_div.sv -----
// Radix-2 restoring divider for the step period, one quotient bit per cycle.
module spg_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [spg_pkg::CLK_W-1:0]   dividend,
    input  logic [spg_pkg::VEL_W-1:0]   divisor,
    output logic                        done,
    output logic [spg_pkg::CLK_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(spg_pkg::CLK_W + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(spg_pkg::CLK_W - 1);

    logic [spg_pkg::VEL_W-1:0] rem_reg;
    logic [spg_pkg::VEL_W-1:0] rem_next;
    logic [spg_pkg::CLK_W-1:0] quo_reg;
    logic [spg_pkg::CLK_W-1:0] quo_next;
    logic [spg_pkg::VEL_W-1:0] dvs_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic                      done_reg;
    logic                      done_next;
    logic [spg_pkg::VEL_W:0]   shifted;
    logic [spg_pkg::VEL_W:0]   diff;
    logic                      ge;

    assign shifted  = {rem_reg, quo_reg[spg_pkg::CLK_W-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign ge       = (shifted >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[spg_pkg::VEL_W-1:0] : shifted[spg_pkg::VEL_W-1:0];
            quo_next = {quo_reg[spg_pkg::CLK_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

endmodule

// ----- design/spg_back.sv -----
// Back end: axis state, pulse timer, move execution and the result register.
module spg_back
#(
    parameter int COUNTER_BITS = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  spg_pkg::req_t               head,
    input  logic                        head_valid,
    output logic                        pop,
    input  logic [spg_pkg::CLK_W-1:0]   clock_rate,
    input  logic [spg_pkg::CFG_W-1:0]   pulse_width,
    input  logic [spg_pkg::CFG_W-1:0]   counter_max,
    input  logic [spg_pkg::POS_W-1:0]   min_position,
    input  logic [spg_pkg::POS_W-1:0]   max_position,
    input  logic [spg_pkg::POS_W-1:0]   home_position,
    input  logic                        invert_pulse,
    output logic                        div_start,
    output logic [spg_pkg::CLK_W-1:0]   div_dividend,
    output logic [spg_pkg::VEL_W-1:0]   div_divisor,
    input  logic                        div_done,
    input  logic [spg_pkg::CLK_W-1:0]   div_quotient,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        step_out,
    output logic                        dir_out,
    output logic [spg_pkg::POS_W-1:0]   position,
    output logic                        homed,
    output logic                        fault,
    output logic                        running,
    output logic                        timer_on,
    output logic                        accepted
);

    localparam int PER_W = (COUNTER_BITS < spg_pkg::CFG_W) ? COUNTER_BITS : spg_pkg::CFG_W;
    localparam logic [spg_pkg::CFG_W-1:0] CMAX_LIMIT =
        spg_pkg::CFG_W'((64'd1 << PER_W) - 64'd1);

    spg_pkg::bk_state_t        state_reg;
    spg_pkg::bk_state_t        state_next;

    logic [spg_pkg::POS_W-1:0] pos_reg;
    logic [spg_pkg::POS_W-1:0] pos_next;
    logic                      dir_reg;
    logic                      dir_next;
    logic                      homed_reg;
    logic                      homed_next;
    logic                      fault_reg;
    logic                      fault_next;
    logic                      run_reg;
    logic                      run_next;
    logic                      tim_reg;
    logic                      tim_next;
    logic [PER_W-1:0]          act_reg;
    logic [PER_W-1:0]          act_next;
    logic [PER_W-1:0]          pend_reg;
    logic [PER_W-1:0]          pend_next;
    logic [PER_W-1:0]          tick_reg;
    logic [PER_W-1:0]          tick_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      step_reg;
    logic                      dir_o_reg;
    logic [spg_pkg::POS_W-1:0] pos_o_reg;
    logic                      homed_o_reg;
    logic                      fault_o_reg;
    logic                      run_o_reg;
    logic                      tim_o_reg;
    logic                      acc_o_reg;

    logic                      out_free;
    logic                      load;
    logic                      acc;
    logic                      fault_rpt;
    logic                      level;
    logic                      in_window;
    logic [spg_pkg::CFG_W-1:0] cmax24;
    logic [PER_W-1:0]          cmax;
    logic [PER_W:0]            tick_inc;
    logic [spg_pkg::CFG_W:0]   minp;
    logic [spg_pkg::CLK_W-1:0] per_lo;

    assign out_free     = !out_valid_reg || !out_stall;
    assign cmax24       = (counter_max > CMAX_LIMIT) ? CMAX_LIMIT : counter_max;
    assign cmax         = PER_W'(cmax24);
    assign tick_inc     = {1'b0, tick_reg} + (PER_W+1)'(1);
    assign minp         = {pulse_width, 1'b0};
    assign per_lo       = (div_quotient < spg_pkg::CLK_W'(minp)) ?
                          spg_pkg::CLK_W'(minp) : div_quotient;
    assign in_window    = ($signed(min_position) < $signed(pos_reg)) &&
                          ($signed(pos_reg) <= $signed(max_position));
    assign div_dividend = clock_rate;
    assign div_divisor  = head.spd;

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load       = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            spg_pkg::BK_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    if (head.op == spg_pkg::OP_MOVE && run_reg && head.spd != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = spg_pkg::BK_DIV;
                    end
                    else
                    begin
                        pop  = 1'b1;
                        load = 1'b1;
                    end
                end
            end
            spg_pkg::BK_DIV:
            begin
                if (div_done && out_free)
                begin
                    pop        = 1'b1;
                    load       = 1'b1;
                    state_next = spg_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = spg_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        dir_next   = dir_reg;
        homed_next = homed_reg;
        fault_next = fault_reg;
        run_next   = run_reg;
        tim_next   = tim_reg;
        act_next   = act_reg;
        pend_next  = pend_reg;
        tick_next  = tick_reg;
        acc        = 1'b0;
        fault_rpt  = fault_reg;
        if (load)
        begin
            case (head.op)
                spg_pkg::OP_TICK:
                begin
                    if (tim_reg)
                    begin
                        if (tick_inc >= {1'b0, act_reg})
                        begin
                            tick_next = '0;
                            act_next  = pend_reg;
                            if (homed_reg && !in_window)
                            begin
                                fault_next = 1'b1;
                                fault_rpt  = 1'b1;
                                tim_next   = 1'b0;
                            end
                            else if (dir_reg)
                            begin
                                pos_next = pos_reg + spg_pkg::POS_W'(1);
                            end
                            else
                            begin
                                pos_next = pos_reg - spg_pkg::POS_W'(1);
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc[PER_W-1:0];
                        end
                    end
                end
                spg_pkg::OP_MOVE:
                begin
                    if (run_reg)
                    begin
                        acc      = 1'b1;
                        dir_next = head.dir;
                        if (head.spd == '0)
                        begin
                            pend_next = cmax;
                            tim_next  = 1'b0;
                            tick_next = '0;
                        end
                        else if (per_lo > spg_pkg::CLK_W'(cmax))
                        begin
                            pend_next = cmax;
                            tim_next  = 1'b0;
                            tick_next = '0;
                        end
                        else
                        begin
                            pend_next = PER_W'(per_lo);
                            if (!tim_reg)
                            begin
                                tim_next  = 1'b1;
                                tick_next = '0;
                                act_next  = PER_W'(per_lo);
                            end
                        end
                    end
                end
                spg_pkg::OP_ENABLE:
                begin
                    run_next = 1'b1;
                end
                spg_pkg::OP_DISABLE:
                begin
                    run_next   = 1'b0;
                    homed_next = 1'b0;
                end
                spg_pkg::OP_HOME:
                begin
                    if (run_reg)
                    begin
                        pos_next   = home_position;
                        homed_next = 1'b1;
                    end
                end
                spg_pkg::OP_ACK:
                begin
                    if (fault_reg)
                    begin
                        tim_next   = 1'b0;
                        tick_next  = '0;
                        fault_next = 1'b0;
                        homed_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        level = tim_next && (spg_pkg::CFG_W'(tick_next) < pulse_width);
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spg_pkg::BK_IDLE;
            pos_reg       <= '0;
            dir_reg       <= 1'b0;
            homed_reg     <= 1'b0;
            fault_reg     <= 1'b0;
            run_reg       <= 1'b0;
            tim_reg       <= 1'b0;
            act_reg       <= '1;
            pend_reg      <= '1;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            dir_reg       <= dir_next;
            homed_reg     <= homed_next;
            fault_reg     <= fault_next;
            run_reg       <= run_next;
            tim_reg       <= tim_next;
            act_reg       <= act_next;
            pend_reg      <= pend_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            step_reg    <= level ^ invert_pulse;
            dir_o_reg   <= dir_next;
            pos_o_reg   <= pos_next;
            homed_o_reg <= homed_next;
            fault_o_reg <= fault_rpt;
            run_o_reg   <= run_next;
            tim_o_reg   <= tim_next;
            acc_o_reg   <= acc;
        end
    end

    assign out_valid = out_valid_reg;
    assign step_out  = step_reg;
    assign dir_out   = dir_o_reg;
    assign position  = pos_o_reg;
    assign homed     = homed_o_reg;
    assign fault     = fault_o_reg;
    assign running   = run_o_reg;
    assign timer_on  = tim_o_reg;
    assign accepted  = acc_o_reg;

endmodule

// ----- design/stepper_pulse_generator_with_limits_unit.sv -----
// Top level: step-pulse generator for one axis with position limits.
//
// Requests (action, speed, move_dir) enter on in_valid/in_stall into a
// two-entry queue; each request yields exactly one result on
// out_valid/out_stall carrying the pulse level, direction, position and flags.
// Tick, enable, disable, set home, acknowledge and moves that need no division
// are handled directly by the back end: the request is written into the queue,
// then its result is loaded into the output register, one request per cycle
// while the output is not stalled. A move that is taken with a nonzero speed
// runs the period divider, one quotient bit per cycle, and holds the back end in
// its divide state until the quotient is done and the output is free.
// A stalled result holds in the output register; the queue keeps accepting
// until both entries are used, then in_stall rises.
// Reset clears position, flags and timer, loads both periods with the counter
// maximum and returns the registers to their documented defaults.
// Registers sit on the APB port at byte address 4*index; pready is tied high.
module stepper_pulse_generator_with_limits_unit
#(
    parameter int COUNTER_BITS = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [4:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [spg_pkg::ACT_W-1:0]   action,
    input  logic [spg_pkg::VEL_W-1:0]   speed,
    input  logic                        move_dir,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        step_out,
    output logic                        dir_out,
    output logic signed [spg_pkg::POS_W-1:0] position,
    output logic                        homed,
    output logic                        fault,
    output logic                        running,
    output logic                        timer_on,
    output logic                        accepted
);

    logic [spg_pkg::CLK_W-1:0] clock_rate_reg;
    logic [spg_pkg::VEL_W-1:0] max_velocity_reg;
    logic [spg_pkg::CFG_W-1:0] pulse_width_reg;
    logic [spg_pkg::CFG_W-1:0] counter_max_reg;
    logic [spg_pkg::POS_W-1:0] min_position_reg;
    logic [spg_pkg::POS_W-1:0] max_position_reg;
    logic [spg_pkg::POS_W-1:0] home_position_reg;
    logic                      invert_pulse_reg;

    logic                      wr_en;
    spg_pkg::reg_idx_t         idx;
    spg_pkg::req_t             head;
    logic                      head_valid;
    logic                      pop;
    logic                      div_start;
    logic [spg_pkg::CLK_W-1:0] div_dividend;
    logic [spg_pkg::VEL_W-1:0] div_divisor;
    logic                      div_done;
    logic [spg_pkg::CLK_W-1:0] div_quotient;
    logic [spg_pkg::POS_W-1:0] pos_w;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = spg_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_rate_reg    <= spg_pkg::CLK_W'(48000000);
            max_velocity_reg  <= spg_pkg::VEL_W'(10000);
            pulse_width_reg   <= spg_pkg::CFG_W'(2);
            counter_max_reg   <= '1;
            min_position_reg  <= {1'b1, {(spg_pkg::POS_W-1){1'b0}}};
            max_position_reg  <= {1'b0, {(spg_pkg::POS_W-1){1'b1}}};
            home_position_reg <= '0;
            invert_pulse_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                spg_pkg::REG_CLOCK_RATE:    clock_rate_reg    <= pwdata[spg_pkg::CLK_W-1:0];
                spg_pkg::REG_MAX_VELOCITY:  max_velocity_reg  <= pwdata[spg_pkg::VEL_W-1:0];
                spg_pkg::REG_PULSE_WIDTH:   pulse_width_reg   <= pwdata[spg_pkg::CFG_W-1:0];
                spg_pkg::REG_COUNTER_MAX:   counter_max_reg   <= pwdata[spg_pkg::CFG_W-1:0];
                spg_pkg::REG_MIN_POSITION:  min_position_reg  <= pwdata;
                spg_pkg::REG_MAX_POSITION:  max_position_reg  <= pwdata;
                spg_pkg::REG_HOME_POSITION: home_position_reg <= pwdata;
                spg_pkg::REG_INVERT_PULSE:  invert_pulse_reg  <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            spg_pkg::REG_CLOCK_RATE:    prdata = 32'(clock_rate_reg);
            spg_pkg::REG_MAX_VELOCITY:  prdata = 32'(max_velocity_reg);
            spg_pkg::REG_PULSE_WIDTH:   prdata = 32'(pulse_width_reg);
            spg_pkg::REG_COUNTER_MAX:   prdata = 32'(counter_max_reg);
            spg_pkg::REG_MIN_POSITION:  prdata = min_position_reg;
            spg_pkg::REG_MAX_POSITION:  prdata = max_position_reg;
            spg_pkg::REG_HOME_POSITION: prdata = home_position_reg;
            spg_pkg::REG_INVERT_PULSE:  prdata = 32'(invert_pulse_reg);
            default:                    prdata = '0;
        endcase
    end

    spg_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .speed        (speed),
        .move_dir     (move_dir),
        .max_velocity (max_velocity_reg),
        .pop          (pop),
        .head         (head),
        .head_valid   (head_valid)
    );

    spg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    spg_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .clock_rate    (clock_rate_reg),
        .pulse_width   (pulse_width_reg),
        .counter_max   (counter_max_reg),
        .min_position  (min_position_reg),
        .max_position  (max_position_reg),
        .home_position (home_position_reg),
        .invert_pulse  (invert_pulse_reg),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .step_out      (step_out),
        .dir_out       (dir_out),
        .position      (pos_w),
        .homed         (homed),
        .fault         (fault),
        .running       (running),
        .timer_on      (timer_on),
        .accepted      (accepted)
    );

    assign position = $signed(pos_w);

endmodule

// ----- design/spg_checker.sv -----
// Checker: port-level properties of the step-pulse generator, bound to the top level.
module spg_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [spg_pkg::POS_W-1:0] position,
    input logic                      homed,
    input logic                      running,
    input logic                      accepted
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position))
        else $error("result changed while stalled");

    // A move is only taken while the driver is enabled.
    a_acc_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> running)
        else $error("move accepted while not running");

    // Homing requires the driver on; disable drops homed.
    a_homed_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && homed |-> running)
        else $error("homed while not running");

endmodule

bind stepper_pulse_generator_with_limits_unit spg_checker u_spg_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .position  (position),
    .homed     (homed),
    .running   (running),
    .accepted  (accepted)
);

// ----- test/tb_stepper_pulse_generator_with_limits_unit.sv -----
// Testbench for the step-pulse generator: directed table, random phases, predictor-checked results.
module tb_stepper_pulse_generator_with_limits_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNTER_BITS = 24;
    localparam logic [31:0] CNT_LIMIT = (32'd1 << COUNTER_BITS) - 32'd1;
    localparam logic [spg_pkg::ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [spg_pkg::ACT_W-1:0] ACT_SPARE7 = 3'd7;
    localparam int PROF_TIGHT = 0;
    localparam int PROF_HIGH = 1;
    localparam int PROF_LOW = 2;
    localparam int PROF_WIDE = 3;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic              step_out;
        logic              dir_out;
        logic signed [31:0] position;
        logic              homed;
        logic              fault;
        logic              running;
        logic              timer_on;
        logic              accepted;
    } axis_out_t;

    typedef struct {
        bit                         is_cfg;
        spg_pkg::reg_idx_t          ri;
        logic [31:0]                val;
        logic [spg_pkg::ACT_W-1:0]  act;
        logic [spg_pkg::VEL_W-1:0]  spd;
        logic                       dir;
        bit                         use_lit;
        axis_out_t                  lit;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid;
    logic in_stall;
    logic [spg_pkg::ACT_W-1:0] action;
    logic [spg_pkg::VEL_W-1:0] speed;
    logic move_dir;
    logic out_valid;
    logic out_stall;
    logic step_out;
    logic dir_out;
    logic signed [spg_pkg::POS_W-1:0] position;
    logic homed;
    logic fault;
    logic running;
    logic timer_on;
    logic accepted;

    stepper_pulse_generator_with_limits_unit #(.COUNTER_BITS(COUNTER_BITS)) DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .speed(speed),
        .move_dir(move_dir),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .step_out(step_out),
        .dir_out(dir_out),
        .position(position),
        .homed(homed),
        .fault(fault),
        .running(running),
        .timer_on(timer_on),
        .accepted(accepted)
    );

    // register mirror
    logic [spg_pkg::CLK_W-1:0] c_clock;
    logic [spg_pkg::VEL_W-1:0] c_maxv;
    logic [spg_pkg::CFG_W-1:0] c_pw;
    logic [spg_pkg::CFG_W-1:0] c_cmax;
    logic signed [31:0] c_min;
    logic signed [31:0] c_max;
    logic signed [31:0] c_home;
    logic c_inv;

    // axis state
    logic signed [31:0] m_pos;
    bit m_dir;
    bit m_homed;
    bit m_fault;
    bit m_run;
    bit m_timer;
    logic [31:0] m_active;
    logic [31:0] m_pending;
    logic [31:0] m_cnt;

    axis_out_t pending_results[$];
    plan_row_t plan[$];
    int unsigned mismatch_count;
    int unsigned issued;
    int unsigned calm_left;
    int unsigned quiet_cycles;
    bit hold_req;
    int unsigned hold_cnt;
    int unsigned burst_len;
    bit burst_stall;
    int unsigned stall_pick;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] eff_cmax();
        return ({8'd0, c_cmax} > CNT_LIMIT) ? CNT_LIMIT : {8'd0, c_cmax};
    endfunction

    function automatic void halt_timer();
        m_timer = 1'b0;
        m_cnt = '0;
    endfunction

    function automatic void reset_axis();
        c_clock = 26'd48000000;
        c_maxv = 24'd10000;
        c_pw = 24'd2;
        c_cmax = 24'hFFFFFF;
        c_min = POS_MIN;
        c_max = POS_MAX;
        c_home = '0;
        c_inv = 1'b0;
        m_pos = '0;
        m_dir = 1'b0;
        m_homed = 1'b0;
        m_fault = 1'b0;
        m_run = 1'b0;
        m_timer = 1'b0;
        m_active = eff_cmax();
        m_pending = eff_cmax();
        m_cnt = '0;
    endfunction

    function automatic void apply_setting(spg_pkg::reg_idx_t ri, logic [31:0] val);
        case (ri)
            spg_pkg::REG_CLOCK_RATE:    c_clock = val[spg_pkg::CLK_W-1:0];
            spg_pkg::REG_MAX_VELOCITY:  c_maxv = val[spg_pkg::VEL_W-1:0];
            spg_pkg::REG_PULSE_WIDTH:   c_pw = val[spg_pkg::CFG_W-1:0];
            spg_pkg::REG_COUNTER_MAX:   c_cmax = val[spg_pkg::CFG_W-1:0];
            spg_pkg::REG_MIN_POSITION:  c_min = val;
            spg_pkg::REG_MAX_POSITION:  c_max = val;
            spg_pkg::REG_HOME_POSITION: c_home = val;
            spg_pkg::REG_INVERT_PULSE:  c_inv = val[0];
            default: ;
        endcase
    endfunction

    function automatic void take_wrap();
        if (m_homed && !((m_pos > c_min) && (m_pos <= c_max)))
        begin
            m_fault = 1'b1;
            halt_timer();
        end
        else if (m_dir)
            m_pos = m_pos + 32'sd1;
        else
            m_pos = m_pos - 32'sd1;
    endfunction

    function automatic void take_tick();
        if (!m_timer)
            return;
        if (m_cnt + 32'd1 >= m_active)
        begin
            m_cnt = '0;
            m_active = m_pending;
            take_wrap();
        end
        else
            m_cnt = m_cnt + 32'd1;
    endfunction

    function automatic void take_move(logic [spg_pkg::VEL_W-1:0] spd, logic dir);
        logic [31:0] s;
        logic [31:0] per;
        logic [31:0] minp;
        logic [31:0] cm;
        cm = eff_cmax();
        m_dir = dir;
        s = {8'd0, (spd > c_maxv) ? c_maxv : spd};
        if (s == 0)
        begin
            m_pending = cm;
            halt_timer();
            return;
        end
        per = {6'd0, c_clock} / s;
        minp = {7'd0, c_pw, 1'b0};
        if (per < minp)
            per = minp;
        if (per > cm)
        begin
            per = cm;
            halt_timer();
        end
        else if (!m_timer)
        begin
            m_timer = 1'b1;
            m_cnt = '0;
            m_active = per;
        end
        m_pending = per;
    endfunction

    function automatic axis_out_t predict_axis(logic [spg_pkg::ACT_W-1:0] act,
                                               logic [spg_pkg::VEL_W-1:0] spd, logic dir);
        axis_out_t r;
        bit took;
        bit fault_seen;
        took = 1'b0;
        case (act)
            spg_pkg::ACT_TICK:
                take_tick();
            spg_pkg::ACT_MOVE:
                if (m_run)
                begin
                    took = 1'b1;
                    take_move(spd, dir);
                end
            spg_pkg::ACT_ENABLE:
                m_run = 1'b1;
            spg_pkg::ACT_DISABLE:
            begin
                m_run = 1'b0;
                m_homed = 1'b0;
            end
            spg_pkg::ACT_HOME:
                if (m_run)
                begin
                    m_pos = c_home;
                    m_homed = 1'b1;
                end
            default: ;
        endcase
        fault_seen = m_fault;
        if (act == spg_pkg::ACT_ACK && m_fault)
        begin
            halt_timer();
            m_fault = 1'b0;
            m_homed = 1'b0;
        end
        r.step_out = (m_timer && m_cnt < {8'd0, c_pw}) ^ c_inv;
        r.dir_out = m_dir;
        r.position = m_pos;
        r.homed = m_homed;
        r.fault = fault_seen;
        r.running = m_run;
        r.timer_on = m_timer;
        r.accepted = took;
        return r;
    endfunction

    function automatic axis_out_t idle_out(logic run, logic dir, logic took);
        axis_out_t r;
        r = '0;
        r.running = run;
        r.dir_out = dir;
        r.accepted = took;
        return r;
    endfunction

    function automatic plan_row_t blank_row();
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.ri = spg_pkg::REG_CLOCK_RATE;
        row.val = '0;
        row.act = spg_pkg::ACT_TICK;
        row.spd = '0;
        row.dir = 1'b0;
        row.use_lit = 1'b0;
        row.lit = '0;
        return row;
    endfunction

    function automatic void add_req(logic [spg_pkg::ACT_W-1:0] act,
                                    logic [spg_pkg::VEL_W-1:0] spd, logic dir);
        plan_row_t row;
        row = blank_row();
        row.act = act;
        row.spd = spd;
        row.dir = dir;
        plan.push_back(row);
    endfunction

    function automatic void add_fixed(logic [spg_pkg::ACT_W-1:0] act,
                                      logic [spg_pkg::VEL_W-1:0] spd, logic dir,
                                      axis_out_t want);
        plan_row_t row;
        row = blank_row();
        row.act = act;
        row.spd = spd;
        row.dir = dir;
        row.use_lit = 1'b1;
        row.lit = want;
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(spg_pkg::reg_idx_t ri, logic [31:0] val);
        plan_row_t row;
        row = blank_row();
        row.is_cfg = 1'b1;
        row.ri = ri;
        row.val = val;
        plan.push_back(row);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_left != 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [spg_pkg::VEL_W-1:0] rand_speed();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return 24'hFFFFFF;
        if (r < 50)
            return spg_pkg::VEL_W'($urandom_range(1, 64));
        return spg_pkg::VEL_W'($urandom);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(logic [spg_pkg::ACT_W-1:0] act,
                                logic [spg_pkg::VEL_W-1:0] spd, logic dir,
                                bit use_lit, axis_out_t lit, bit keep_going);
        axis_out_t want;
        int unsigned gap;
        in_valid <= 1'b1;
        action <= act;
        speed <= spd;
        move_dir <= dir;
        do
            @(posedge clk);
        while (in_stall);
        want = predict_axis(act, spd, dir);
        pending_results.push_back(use_lit ? lit : want);
        gap = keep_going ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            action <= spg_pkg::ACT_W'($urandom);
            speed <= spg_pkg::VEL_W'($urandom);
            move_dir <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(logic [spg_pkg::ACT_W-1:0] act, logic [spg_pkg::VEL_W-1:0] spd,
                         logic dir);
        send_request(act, spd, dir, 1'b0, '0, 1'b0);
        if (act <= spg_pkg::ACT_ACK)
            issued++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_setting(spg_pkg::reg_idx_t ri, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {ri, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apply_setting(ri, val);
        @(posedge clk);
    endtask

    task automatic apply_profile(int kind);
        logic [31:0] vals[8];
        int signed home;
        home = 0;
        case (kind)
            PROF_TIGHT:
            begin
                home = $urandom_range(0, 40) - 20;
                vals[spg_pkg::REG_CLOCK_RATE] = $urandom_range(1, 400);
                vals[spg_pkg::REG_MAX_VELOCITY] = ($urandom_range(0, 3) == 0)
                                                  ? $urandom_range(1, 24'hFFFFFF)
                                                  : $urandom_range(1, 100);
                vals[spg_pkg::REG_PULSE_WIDTH] = $urandom_range(2, 6);
                vals[spg_pkg::REG_COUNTER_MAX] = $urandom_range(4, 80);
                vals[spg_pkg::REG_MIN_POSITION] = home - int'($urandom_range(1, 20));
                vals[spg_pkg::REG_MAX_POSITION] = home + int'($urandom_range(0, 20)) - 3;
                vals[spg_pkg::REG_HOME_POSITION] = home;
                vals[spg_pkg::REG_INVERT_PULSE] = $urandom_range(0, 1);
            end
            PROF_HIGH:
            begin
                vals[spg_pkg::REG_CLOCK_RATE] = 48000000;
                vals[spg_pkg::REG_MAX_VELOCITY] = 24'hFFFFFF;
                vals[spg_pkg::REG_PULSE_WIDTH] = 2;
                vals[spg_pkg::REG_COUNTER_MAX] = 24'hFFFFFF;
                vals[spg_pkg::REG_MIN_POSITION] = POS_MIN;
                vals[spg_pkg::REG_MAX_POSITION] = POS_MAX;
                vals[spg_pkg::REG_HOME_POSITION] = $urandom_range(0, 1) ? POS_MAX - 2
                                                                        : POS_MIN + 2;
                vals[spg_pkg::REG_INVERT_PULSE] = 1;
            end
            PROF_LOW:
            begin
                vals[spg_pkg::REG_CLOCK_RATE] = 1;
                vals[spg_pkg::REG_MAX_VELOCITY] = 1;
                vals[spg_pkg::REG_PULSE_WIDTH] = 2;
                vals[spg_pkg::REG_COUNTER_MAX] = 4;
                vals[spg_pkg::REG_MIN_POSITION] = POS_MIN;
                vals[spg_pkg::REG_MAX_POSITION] = POS_MAX;
                vals[spg_pkg::REG_HOME_POSITION] = $urandom_range(0, 1) ? POS_MIN + 1
                                                                        : POS_MAX - 1;
                vals[spg_pkg::REG_INVERT_PULSE] = 0;
            end
            default:
            begin
                vals[spg_pkg::REG_CLOCK_RATE] = $urandom_range(1, 48000000);
                vals[spg_pkg::REG_MAX_VELOCITY] = $urandom_range(1, 24'hFFFFFF);
                vals[spg_pkg::REG_PULSE_WIDTH] = $urandom_range(0, 1)
                                                 ? $urandom_range(2, 16)
                                                 : $urandom_range(2, 24'hFFFFFF);
                vals[spg_pkg::REG_COUNTER_MAX] = $urandom_range(4, 24'hFFFFFF);
                vals[spg_pkg::REG_MIN_POSITION] = $urandom;
                vals[spg_pkg::REG_MAX_POSITION] = $urandom;
                vals[spg_pkg::REG_HOME_POSITION] = $urandom;
                vals[spg_pkg::REG_INVERT_PULSE] = $urandom_range(0, 1);
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_setting(spg_pkg::reg_idx_t'(i), vals[i]);
    endtask

    task automatic run_phase(int kind, int unsigned n_items);
        int unsigned target;
        int unsigned len;
        drain_results();
        apply_profile(kind);
        target = issued + n_items;
        while (issued < target)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                if ($urandom_range(0, 3) != 0)
                    issue(spg_pkg::ACT_ENABLE, spg_pkg::VEL_W'($urandom), 1'($urandom));
                if ($urandom_range(0, 1) != 0)
                    issue(spg_pkg::ACT_HOME, spg_pkg::VEL_W'($urandom), 1'($urandom));
                issue(spg_pkg::ACT_MOVE, rand_speed(), 1'($urandom));
                len = $urandom_range(4, 40);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        issue(spg_pkg::ACT_MOVE, rand_speed(), 1'($urandom));
                    else
                        issue(spg_pkg::ACT_TICK, spg_pkg::VEL_W'($urandom), 1'($urandom));
                end
                if ($urandom_range(0, 1) != 0)
                    issue(spg_pkg::ACT_ACK, spg_pkg::VEL_W'($urandom), 1'($urandom));
                if ($urandom_range(0, 4) == 0)
                    issue(spg_pkg::ACT_DISABLE, spg_pkg::VEL_W'($urandom), 1'($urandom));
            end
            else
            begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    issue(spg_pkg::ACT_W'($urandom_range(0, 7)), spg_pkg::VEL_W'($urandom),
                          1'($urandom));
            end
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt != 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (burst_len == 0)
            begin
                stall_pick = $urandom_range(0, 99);
                burst_stall = stall_pick >= 80;
                if (stall_pick < 35)
                    burst_len = $urandom_range(10, 60);
                else if (stall_pick < 80)
                    burst_len = $urandom_range(1, 4);
                else if (stall_pick < 96)
                    burst_len = $urandom_range(1, 3);
                else
                    burst_len = $urandom_range(10, 40);
            end
            burst_len--;
            out_stall <= burst_stall;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request waiting", 32'(position), 0);
            else
            begin
                axis_out_t want;
                want = pending_results.pop_front();
                if (step_out !== want.step_out)
                    report_mismatch("step_out", 32'(step_out), 32'(want.step_out));
                if (dir_out !== want.dir_out)
                    report_mismatch("dir_out", 32'(dir_out), 32'(want.dir_out));
                if (position !== want.position)
                    report_mismatch("position", position, want.position);
                if (homed !== want.homed)
                    report_mismatch("homed", 32'(homed), 32'(want.homed));
                if (fault !== want.fault)
                    report_mismatch("fault", 32'(fault), 32'(want.fault));
                if (running !== want.running)
                    report_mismatch("running", 32'(running), 32'(want.running));
                if (timer_on !== want.timer_on)
                    report_mismatch("timer_on", 32'(timer_on), 32'(want.timer_on));
                if (accepted !== want.accepted)
                    report_mismatch("accepted", 32'(accepted), 32'(want.accepted));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("stepper_pulse_generator_with_limits_unit test failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        action <= spg_pkg::ACT_TICK;
        speed <= '0;
        move_dir <= 1'b0;
        out_stall <= 1'b0;
        mismatch_count = 0;
        issued = 0;
        calm_left = 0;
        hold_req = 1'b0;
        hold_cnt = 0;
        burst_len = 0;
        reset_axis();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: nothing runs until enabled
        add_fixed(spg_pkg::ACT_TICK, 24'd0, 1'b0, idle_out(1'b0, 1'b0, 1'b0));
        add_fixed(spg_pkg::ACT_MOVE, 24'd100, 1'b1, idle_out(1'b0, 1'b0, 1'b0));
        add_fixed(spg_pkg::ACT_HOME, 24'd0, 1'b0, idle_out(1'b0, 1'b0, 1'b0));
        add_fixed(spg_pkg::ACT_ACK, 24'd0, 1'b0, idle_out(1'b0, 1'b0, 1'b0));
        add_fixed(spg_pkg::ACT_ENABLE, 24'd0, 1'b0, idle_out(1'b1, 1'b0, 1'b0));
        add_fixed(ACT_SPARE6, 24'hFFFFFF, 1'b1, idle_out(1'b1, 1'b0, 1'b0));
        add_fixed(ACT_SPARE7, 24'd0, 1'b0, idle_out(1'b1, 1'b0, 1'b0));
        add_fixed(spg_pkg::ACT_MOVE, 24'd0, 1'b1, idle_out(1'b1, 1'b1, 1'b1));
        add_req(spg_pkg::ACT_MOVE, 24'hFFFFFF, 1'b0);
        add_req(spg_pkg::ACT_TICK, 24'd0, 1'b0);
        add_req(spg_pkg::ACT_MOVE, 24'd1, 1'b1);
        // short periods, home outside the window, inverted pulse
        add_cfg(spg_pkg::REG_CLOCK_RATE, 32'd20);
        add_cfg(spg_pkg::REG_MAX_VELOCITY, 32'hFFFFFF);
        add_cfg(spg_pkg::REG_PULSE_WIDTH, 32'd2);
        add_cfg(spg_pkg::REG_COUNTER_MAX, 32'd4);
        add_cfg(spg_pkg::REG_MIN_POSITION, -32'sd2);
        add_cfg(spg_pkg::REG_MAX_POSITION, 32'sd2);
        add_cfg(spg_pkg::REG_HOME_POSITION, 32'sd3);
        add_cfg(spg_pkg::REG_INVERT_PULSE, 32'd1);
        add_req(spg_pkg::ACT_HOME, 24'd0, 1'b0);
        add_req(spg_pkg::ACT_MOVE, 24'd5, 1'b1);
        repeat (4) add_req(spg_pkg::ACT_TICK, 24'd0, 1'b0);
        add_req(spg_pkg::ACT_MOVE, 24'd10, 1'b0);
        repeat (2) add_req(spg_pkg::ACT_TICK, 24'd0, 1'b0);
        add_req(spg_pkg::ACT_ACK, 24'd0, 1'b0);
        add_req(spg_pkg::ACT_ACK, 24'd0, 1'b0);
        add_req(spg_pkg::ACT_DISABLE, 24'd0, 1'b0);
        // widest pulse: minimum period beyond the counter
        add_cfg(spg_pkg::REG_CLOCK_RATE, 32'd48000000);
        add_cfg(spg_pkg::REG_PULSE_WIDTH, 32'hFFFFFF);
        add_cfg(spg_pkg::REG_COUNTER_MAX, 32'hFFFFFF);
        add_cfg(spg_pkg::REG_MIN_POSITION, POS_MIN);
        add_cfg(spg_pkg::REG_MAX_POSITION, POS_MAX);
        add_cfg(spg_pkg::REG_HOME_POSITION, POS_MAX);
        add_cfg(spg_pkg::REG_INVERT_PULSE, 32'd0);
        add_req(spg_pkg::ACT_ENABLE, 24'd0, 1'b0);
        add_req(spg_pkg::ACT_HOME, 24'd0, 1'b0);
        add_req(spg_pkg::ACT_MOVE, 24'hFFFFFF, 1'b1);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain_results();
                write_setting(plan[i].ri, plan[i].val);
            end
            else
                send_request(plan[i].act, plan[i].spd, plan[i].dir, plan[i].use_lit,
                             plan[i].lit, 1'b0);
        end

        run_phase(PROF_TIGHT, 135);
        run_phase(PROF_HIGH, 135);

        // hold the output off while requests keep coming, so the queue fills
        drain_results();
        issue(spg_pkg::ACT_ENABLE, 24'd0, 1'b0);
        hold_req = 1'b1;
        repeat (16)
            send_request(spg_pkg::ACT_TICK, spg_pkg::VEL_W'($urandom), 1'($urandom),
                         1'b0, '0, 1'b1);
        issued += 16;

        run_phase(PROF_TIGHT, 135);
        run_phase(PROF_LOW, 135);
        run_phase(PROF_WIDE, 135);
        run_phase(PROF_TIGHT, 135);
        run_phase(PROF_WIDE, 135);
        run_phase(PROF_TIGHT, 135);

        drain_results();
        repeat (32) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("stepper_pulse_generator_with_limits_unit test passed");
        else
            $display("stepper_pulse_generator_with_limits_unit test failed");
        $finish;
    end

endmodule
